// File: rtl/core/muart_pkg.sv
// ----------------------------------------------------------------------------
// muart_pkg
// Shared codes, bit positions and the result word type of the MIDI UART block.
// ----------------------------------------------------------------------------
package muart_pkg;

    // command codes carried on s_tuser
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_LINE_BYTE = 3'd1;
    localparam logic [2:0] CMD_RD_STATUS = 3'd2;
    localparam logic [2:0] CMD_RD_DATA   = 3'd3;
    localparam logic [2:0] CMD_WR_CMD    = 3'd4;
    localparam logic [2:0] CMD_WR_DATA   = 3'd5;

    // command register bits
    localparam int CM_TXEN_BIT = 0;
    localparam int CM_TXIE_BIT = 1;
    localparam int CM_RXEN_BIT = 2;
    localparam int CM_RXIE_BIT = 3;
    localparam int CM_ER_BIT   = 4;
    localparam int CM_IR_BIT   = 7;

    localparam logic [7:0] CHAR_TICKS_RESET = 8'd10;

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int SDATA_W = 8;
    localparam int MDATA_W = 24;

    // one result word; read_value sits in the low bits
    typedef struct packed {
        logic              line_byte_dropped;
        logic              line_can_send;
        logic              irq;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
        logic [BYTE_W-1:0] read_value;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// File: rtl/core/muart_core.sv
// ----------------------------------------------------------------------------
// muart_core
// Register state of the UART and the single-pass update for one command word.
// ----------------------------------------------------------------------------
module muart_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [7:0]               cfg_wr_data,
    input  logic                     item_acc,
    input  logic [2:0]               item_cmd,
    input  logic [7:0]               item_data,
    output muart_pkg::result_t       result
);
    import muart_pkg::*;

    logic [7:0] char_ticks_reg, char_ticks_next;
    logic       tx_rdy_reg, tx_rdy_next;
    logic       rx_rdy_reg, rx_rdy_next;
    logic       ovr_reg, ovr_next;
    logic       txen_reg, txen_next;
    logic       txie_reg, txie_next;
    logic       rxen_reg, rxen_next;
    logic       rxie_reg, rxie_next;
    logic [7:0] rx_buf_reg, rx_buf_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] held_reg, held_next;
    logic       rx_ready_reg, rx_ready_next;
    logic [7:0] rx_cnt_reg, rx_cnt_next;
    logic [7:0] tx_cnt_reg, tx_cnt_next;
    logic       rx_irq_reg, rx_irq_next;
    logic       tx_irq_reg, tx_irq_next;

    logic [7:0] char_len;
    logic [7:0] status_byte;

    assign char_len    = (char_ticks_reg == 8'd0) ? 8'd1 : char_ticks_reg;
    // framing error bit 5 is never set
    assign status_byte = {3'b000, ovr_reg, 2'b00, rx_rdy_reg, tx_rdy_reg};

    always_comb begin
        char_ticks_next = cfg_wr_en ? cfg_wr_data : char_ticks_reg;
        tx_rdy_next   = tx_rdy_reg;
        rx_rdy_next   = rx_rdy_reg;
        ovr_next      = ovr_reg;
        txen_next     = txen_reg;
        txie_next     = txie_reg;
        rxen_next     = rxen_reg;
        rxie_next     = rxie_reg;
        rx_buf_next   = rx_buf_reg;
        shift_next    = shift_reg;
        held_next     = held_reg;
        rx_ready_next = rx_ready_reg;
        rx_cnt_next   = rx_cnt_reg;
        tx_cnt_next   = tx_cnt_reg;
        rx_irq_next   = rx_irq_reg;
        tx_irq_next   = tx_irq_reg;
        result        = '0;

        if (item_acc) begin
            unique case (item_cmd)
                CMD_TICK: begin
                    if (rx_cnt_reg != 8'd0) begin
                        rx_cnt_next = rx_cnt_reg - 8'd1;
                        if (rx_cnt_reg == 8'd1) begin
                            rx_ready_next = 1'b1;
                        end
                    end
                    if (tx_cnt_reg != 8'd0) begin
                        tx_cnt_next = tx_cnt_reg - 8'd1;
                        if (tx_cnt_reg == 8'd1) begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = shift_reg;
                            // held byte waiting: start it now
                            if (!tx_rdy_reg) begin
                                tx_rdy_next = 1'b1;
                                if (txie_reg) begin
                                    tx_irq_next = 1'b1;
                                end
                                shift_next  = held_reg;
                                tx_cnt_next = char_len;
                            end
                        end
                    end
                end
                CMD_LINE_BYTE: begin
                    if (!rxen_reg || !rx_ready_reg) begin
                        result.line_byte_dropped = 1'b1;
                    end else begin
                        if (rx_rdy_reg) begin
                            ovr_next = 1'b1;
                        end else begin
                            rx_buf_next = item_data;
                            rx_rdy_next = 1'b1;
                            if (rxie_reg) begin
                                rx_irq_next = 1'b1;
                            end
                        end
                        rx_ready_next = 1'b0;
                        rx_cnt_next   = char_len;
                    end
                end
                CMD_RD_STATUS: begin
                    result.read_value = status_byte;
                end
                CMD_RD_DATA: begin
                    rx_rdy_next       = 1'b0;
                    rx_irq_next       = 1'b0;
                    result.read_value = rx_buf_reg;
                end
                CMD_WR_CMD: begin
                    if (item_data[CM_IR_BIT]) begin
                        tx_rdy_next   = 1'b0;
                        rx_rdy_next   = 1'b0;
                        ovr_next      = 1'b0;
                        txen_next     = 1'b0;
                        txie_next     = 1'b0;
                        rxen_next     = 1'b0;
                        rxie_next     = 1'b0;
                        rx_buf_next   = 8'd0;
                        shift_next    = 8'd0;
                        held_next     = 8'd0;
                        rx_ready_next = 1'b0;
                        rx_cnt_next   = 8'd0;
                        tx_cnt_next   = 8'd0;
                        rx_irq_next   = 1'b0;
                        tx_irq_next   = 1'b0;
                    end else if (item_data[CM_ER_BIT]) begin
                        ovr_next = 1'b0;
                    end else begin
                        txen_next = item_data[CM_TXEN_BIT];
                        txie_next = item_data[CM_TXIE_BIT];
                        rxen_next = item_data[CM_RXEN_BIT];
                        rxie_next = item_data[CM_RXIE_BIT];
                        if (rxen_reg != item_data[CM_RXEN_BIT]) begin
                            if (item_data[CM_RXEN_BIT]) begin
                                rx_ready_next = 1'b1;
                            end else begin
                                rx_ready_next = 1'b0;
                                rx_cnt_next   = 8'd0;
                                rx_rdy_next   = 1'b0;
                            end
                        end
                        if (txen_reg != item_data[CM_TXEN_BIT]) begin
                            if (item_data[CM_TXEN_BIT]) begin
                                tx_rdy_next = 1'b1;
                            end else begin
                                tx_rdy_next = 1'b0;
                                tx_cnt_next = 8'd0;
                            end
                        end
                        rx_irq_next = item_data[CM_RXIE_BIT] && rx_rdy_next;
                        tx_irq_next = item_data[CM_TXIE_BIT] && tx_rdy_next;
                    end
                end
                CMD_WR_DATA: begin
                    if (txen_reg) begin
                        if (tx_cnt_reg != 8'd0) begin
                            held_next   = item_data;
                            tx_rdy_next = 1'b0;
                            tx_irq_next = 1'b0;
                        end else begin
                            shift_next  = item_data;
                            tx_cnt_next = char_len;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        result.irq           = rx_irq_next || tx_irq_next;
        result.line_can_send = rxen_next && rx_ready_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_ticks_reg <= CHAR_TICKS_RESET;
            tx_rdy_reg     <= 1'b0;
            rx_rdy_reg     <= 1'b0;
            ovr_reg        <= 1'b0;
            txen_reg       <= 1'b0;
            txie_reg       <= 1'b0;
            rxen_reg       <= 1'b0;
            rxie_reg       <= 1'b0;
            rx_buf_reg     <= 8'd0;
            shift_reg      <= 8'd0;
            held_reg       <= 8'd0;
            rx_ready_reg   <= 1'b0;
            rx_cnt_reg     <= 8'd0;
            tx_cnt_reg     <= 8'd0;
            rx_irq_reg     <= 1'b0;
            tx_irq_reg     <= 1'b0;
        end else begin
            char_ticks_reg <= char_ticks_next;
            tx_rdy_reg     <= tx_rdy_next;
            rx_rdy_reg     <= rx_rdy_next;
            ovr_reg        <= ovr_next;
            txen_reg       <= txen_next;
            txie_reg       <= txie_next;
            rxen_reg       <= rxen_next;
            rxie_reg       <= rxie_next;
            rx_buf_reg     <= rx_buf_next;
            shift_reg      <= shift_next;
            held_reg       <= held_next;
            rx_ready_reg   <= rx_ready_next;
            rx_cnt_reg     <= rx_cnt_next;
            tx_cnt_reg     <= tx_cnt_next;
            rx_irq_reg     <= rx_irq_next;
            tx_irq_reg     <= tx_irq_next;
        end
    end

`ifndef SYNTHESIS
    // receiver counts down only while busy
    a_rx_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_cnt_reg != 8'd0) |-> !rx_ready_reg)
        else $error("receiver ready while character time running");
    // idle enabled transmitter always shows transmit ready
    a_tx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (txen_reg && tx_cnt_reg == 8'd0) |-> tx_rdy_reg)
        else $error("idle transmitter without transmit ready");
    a_rx_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_irq_reg |-> rx_rdy_reg)
        else $error("receive irq without receive ready");
    a_tx_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_irq_reg |-> tx_rdy_reg)
        else $error("transmit irq without transmit ready");
`endif

endmodule

// File: rtl/core/muart_out_buf.sv
// ----------------------------------------------------------------------------
// muart_out_buf
// Result register with a skid stage so a word is taken while one waits.
// ----------------------------------------------------------------------------
module muart_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  muart_pkg::result_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output muart_pkg::result_t  out_word
);
    import muart_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    in_acc;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            main_valid_next = skid_valid_reg || in_acc;
            main_next       = skid_valid_reg ? skid_reg : in_word;
            skid_valid_next = 1'b0;
        end else if (in_acc) begin
            skid_valid_next = 1'b1;
            skid_next       = in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/core/midi_uart_register_block.sv
// ----------------------------------------------------------------------------
// midi_uart_register_block
// MIDI UART seen through status, data and command registers, one word per cmd.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------
//  s_       | in  | s_tvalid / s_tready   | tuser: command, tdata: data_byte
//  m_       | out | m_tvalid / m_tready   | tdata: result word (see port)
//  cfg_     | in  | cfg_wr_en             | cfg_wr_data: char_ticks
//
//  One input word per cycle while s_tready is high; every word yields exactly
//  one result word, registered in the result register or, if that waits, the skid.
//  State updates happen in the accept cycle through one pass of flag logic.
//  A two-deep result buffer (register plus skid) keeps s_tready high while a
//  result waits; s_tready drops only when both entries are full.
//  aresetn is synchronous, active low; char_ticks returns to 10.
//
module midi_uart_register_block (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,     // char_ticks
    // command words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [7:0] data_byte
    input  logic [2:0]  s_tuser,         // [2:0] command
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata          // [7:0] read_value, [8] tx_valid,
                                         // [16:9] tx_byte, [17] irq,
                                         // [18] line_can_send,
                                         // [19] line_byte_dropped, rest zero
);
    import muart_pkg::*;

    logic    s_acc;
    result_t core_result;
    result_t out_word;

    // a word enters the core only in its accept cycle
    assign s_acc = s_tvalid && s_tready;

    muart_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_acc    (s_acc),
        .item_cmd    (s_tuser),
        .item_data   (s_tdata),
        .result      (core_result)
    );

    muart_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // pad result word up to whole bytes
    assign m_tdata = {{(MDATA_W-RESULT_W){1'b0}}, out_word};

endmodule
